### sv/bps_pkg.sv
package bps_pkg;

   // vector, square root and divider widths
   localparam int MAG_W     = 16;
   localparam int LEN_W     = 32;
   localparam int SQ_W      = 61;
   localparam int SQ_STEPS  = 30;
   localparam int S_W       = 31;
   localparam int Q_W       = 15;
   localparam int DIV_STEPS = 15;
   localparam int REM_W     = 46;
   localparam int UNIT_W    = 16;
   localparam int FRAC_SH   = 28;

   localparam logic [Q_W-1:0] ONE_Q14 = 15'd16384;

   // shading constants, Q0.16 (specular one already times 255, so Q7.16)
   localparam logic [15:0] KA_Q16    = 16'd14418;
   localparam logic [15:0] KD_Q16    = 16'd45875;
   localparam logic [22:0] KS255_Q16 = 23'd4679250;

   // register indexes
   localparam logic [2:0] REG_LIGHT_X  = 3'd0;
   localparam logic [2:0] REG_LIGHT_Y  = 3'd1;
   localparam logic [2:0] REG_LIGHT_Z  = 3'd2;
   localparam logic [2:0] REG_CAMERA_X = 3'd3;
   localparam logic [2:0] REG_CAMERA_Y = 3'd4;
   localparam logic [2:0] REG_CAMERA_Z = 3'd5;
   localparam logic [2:0] REG_COLOUR   = 3'd6;

   typedef logic [MAG_W-1:0] mag_type;
   typedef logic signed [UNIT_W-1:0] unit_type;
   typedef unit_type [2:0] uvec_type;
   typedef logic [2:0][15:0] pos_type;

   typedef struct packed {
      logic [SQ_W-1:0] x;
      logic [SQ_W-1:0] r;
   } sqrt_type;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [Q_W-1:0]   q;
   } div_type;

   // status from the light vector unit
   typedef struct packed {
      logic     busy;
      uvec_type light_dir;
      uvec_type half_dir;
   } light_sts_type;

   // magnitude of a 17-bit signed value whose magnitude fits 16 bits
   function automatic mag_type abs17(logic signed [16:0] v);
      logic [16:0] a;
      a = v[16] ? 17'(-v) : 17'(v);
      return a[MAG_W-1:0];
   endfunction

   // one digit of the integer square root, b = 4^k
   function automatic sqrt_type sqrt_step(sqrt_type a, logic [4:0] k);
      logic [SQ_W-1:0] b;
      logic [SQ_W-1:0] t;
      sqrt_type o;
      b = SQ_W'(1) << {k, 1'b0};
      t = a.r + b;
      if (a.x >= t) begin
         o.x = a.x - t;
         o.r = (a.r >> 1) + b;
      end else begin
         o.x = a.x;
         o.r = a.r >> 1;
      end
      return o;
   endfunction

   // one quotient bit of restoring division
   function automatic div_type div_step(div_type a, logic [S_W-1:0] s, logic [3:0] i);
      logic [REM_W-1:0] d;
      div_type o;
      d = REM_W'(s) << i;
      o = a;
      if (a.rem >= d) begin
         o.rem = a.rem - d;
         o.q   = a.q | (Q_W'(1) << i);
      end
      return o;
   endfunction

   // limit to one, apply sign, zero vector gives zero
   function automatic unit_type unit_comp(logic [Q_W-1:0] q, logic neg, logic zero);
      logic [Q_W-1:0] c;
      unit_type u;
      c = (q > ONE_Q14) ? ONE_Q14 : q;
      u = unit_type'({1'b0, c});
      return zero ? unit_type'(0) : (neg ? -u : u);
   endfunction

endpackage

### sv/blinn_phong_pixel_shade.sv
// Blinn-Phong shader for one pixel per clock when the input is not held. Each
// word on req carries a base colour and an unnormalized Q1.14 surface normal;
// the shaded colour leaves on rsp, and a new word is taken every cycle while
// the output side keeps up and no vector rebuild runs. A normalizer of a
// 30-stage square root and three 15-stage restoring dividers feeds an
// 11-stage dot product, pow16 and colour pipeline. After reset and after
// every register write an iterative unit rebuilds the unit light, view and
// half vectors (per vector the squared length, the root digit by digit, then
// a restoring division per component); req_tready stays low during that pass.
// A two-entry output register plus skid stage decouples rsp_tready from the
// pipeline. Registers: 0..2 light position, 3..5 camera position (signed
// Q8.8), 6 light colour (red 29:20, green 19:10, blue 9:0, Q2.8).
module blinn_phong_pixel_shade (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // pixel_rgb, normal_x, normal_y, normal_z
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // shaded_rgb
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   bps_pkg::pos_type       light_pos_ff;
   bps_pkg::pos_type       camera_pos_ff;
   logic [29:0]            colour_ff;
   bps_pkg::light_sts_type sts;
   logic [2:0]             csr_idx;
   logic                   csr_wr;

   logic                   en;
   logic                   req_accept;
   logic                   n_valid;
   logic [23:0]            n_rgb;
   bps_pkg::uvec_type      n_unit;
   logic                   p_valid;
   logic [23:0]            p_rgb;

   logic                   rsp_valid_ff;
   logic [23:0]            rsp_data_ff;
   logic                   skid_valid_ff;
   logic [23:0]            skid_data_ff;

   // register port
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[4:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         light_pos_ff  <= {16'd1024, 16'd1536, 16'd640};
         camera_pos_ff <= {16'hff00, 16'd0, 16'd0};
         colour_ff     <= 30'd268697856;
      end else if (csr_wr) begin
         case (csr_idx)
            bps_pkg::REG_LIGHT_X:  light_pos_ff[0]  <= csr_pwdata[15:0];
            bps_pkg::REG_LIGHT_Y:  light_pos_ff[1]  <= csr_pwdata[15:0];
            bps_pkg::REG_LIGHT_Z:  light_pos_ff[2]  <= csr_pwdata[15:0];
            bps_pkg::REG_CAMERA_X: camera_pos_ff[0] <= csr_pwdata[15:0];
            bps_pkg::REG_CAMERA_Y: camera_pos_ff[1] <= csr_pwdata[15:0];
            bps_pkg::REG_CAMERA_Z: camera_pos_ff[2] <= csr_pwdata[15:0];
            bps_pkg::REG_COLOUR:   colour_ff        <= csr_pwdata[29:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         bps_pkg::REG_LIGHT_X:  csr_prdata = 32'(light_pos_ff[0]);
         bps_pkg::REG_LIGHT_Y:  csr_prdata = 32'(light_pos_ff[1]);
         bps_pkg::REG_LIGHT_Z:  csr_prdata = 32'(light_pos_ff[2]);
         bps_pkg::REG_CAMERA_X: csr_prdata = 32'(camera_pos_ff[0]);
         bps_pkg::REG_CAMERA_Y: csr_prdata = 32'(camera_pos_ff[1]);
         bps_pkg::REG_CAMERA_Z: csr_prdata = 32'(camera_pos_ff[2]);
         bps_pkg::REG_COLOUR:   csr_prdata = 32'(colour_ff);
         default:               csr_prdata = '0;
      endcase
   end

   // derived light and half vectors
   bps_light_unit u_light (
      .clock      (clock),
      .reset      (reset),
      .start      (csr_wr),
      .light_pos  (light_pos_ff),
      .camera_pos (camera_pos_ff),
      .sts        (sts)
   );

   // pipeline advances unless the skid stage holds a word
   assign en         = !skid_valid_ff;
   assign req_tready = en && !sts.busy;
   assign req_accept = req_tvalid && req_tready;

   bps_norm_pipe u_norm (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_accept),
      .in_rgb    (req_tdata[23:0]),
      .in_normal (bps_pkg::uvec_type'(req_tdata[71:24])),
      .out_valid (n_valid),
      .out_rgb   (n_rgb),
      .out_unit  (n_unit)
   );

   bps_shade_pipe u_shade (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (n_valid),
      .in_rgb       (n_rgb),
      .in_unit      (n_unit),
      .light_dir    (sts.light_dir),
      .half_dir     (sts.half_dir),
      .light_colour (colour_ff),
      .out_valid    (p_valid),
      .out_rgb      (p_rgb)
   );

   // output register and skid stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_tready) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (p_valid) begin
         if (!rsp_valid_ff || rsp_tready) begin
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_tready) rsp_data_ff <= skid_data_ff;
      end else if (p_valid) begin
         if (!rsp_valid_ff || rsp_tready) rsp_data_ff <= p_rgb;
         else skid_data_ff <= p_rgb;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // checks
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_tvalid)
      else $error("skid stage holds a word while the output is empty");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      sts.busy |-> !req_tready)
      else $error("input taken while light vectors are being rebuilt");

   a_write_rebuilds: assert property (@(posedge clock) disable iff (reset)
      csr_wr |=> sts.busy)
      else $error("register write did not start a vector rebuild");

   a_skid_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_tvalid && !rsp_tready))
      else $error("skid stage filled without an output stall");

endmodule

### sv/bps_norm_pipe.sv
module bps_norm_pipe (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic [23:0]        in_rgb,
   input  bps_pkg::uvec_type  in_normal,
   output logic               out_valid,
   output logic [23:0]        out_rgb,
   output bps_pkg::uvec_type  out_unit
);

   typedef struct packed {
      logic                      valid;
      logic [23:0]               rgb;
      logic [2:0]                neg;
      bps_pkg::mag_type [2:0]    mag;
   } nrm_a_type;

   typedef struct packed {
      logic                        valid;
      logic [23:0]                 rgb;
      logic [2:0]                  neg;
      bps_pkg::mag_type [2:0]      mag;
      logic [bps_pkg::LEN_W-1:0]   len2;
   } nrm_b_type;

   typedef struct packed {
      logic                      valid;
      logic [23:0]               rgb;
      logic [2:0]                neg;
      logic                      zero;
      bps_pkg::mag_type [2:0]    mag;
      bps_pkg::sqrt_type         sr;
   } nrm_sq_type;

   typedef struct packed {
      logic                      valid;
      logic [23:0]               rgb;
      logic [2:0]                neg;
      logic                      zero;
      logic [bps_pkg::S_W-1:0]   s;
      bps_pkg::div_type [2:0]    dv;
   } nrm_div_type;

   nrm_a_type   a_ff, a_in;
   nrm_b_type   b_ff, b_in;
   nrm_sq_type  sq_ff [0:bps_pkg::SQ_STEPS];
   nrm_sq_type  sq_in [0:bps_pkg::SQ_STEPS];
   nrm_div_type div_ff [0:bps_pkg::DIV_STEPS];
   nrm_div_type div_in [0:bps_pkg::DIV_STEPS];
   logic              out_valid_ff;
   logic [23:0]       out_rgb_ff;
   bps_pkg::uvec_type out_unit_ff, out_unit_in;

   // sign and magnitude
   always_comb begin
      a_in.valid = in_valid;
      a_in.rgb   = in_rgb;
      for (int i = 0; i < 3; i++) begin
         a_in.neg[i] = in_normal[i][15];
         a_in.mag[i] = bps_pkg::abs17({in_normal[i][15], in_normal[i]});
      end
   end

   // squared length
   always_comb begin
      logic [31:0] sq;
      b_in.valid = a_ff.valid;
      b_in.rgb   = a_ff.rgb;
      b_in.neg   = a_ff.neg;
      b_in.mag   = a_ff.mag;
      b_in.len2  = '0;
      for (int i = 0; i < 3; i++) begin
         sq = 32'(a_ff.mag[i]) * 32'(a_ff.mag[i]);
         b_in.len2 = b_in.len2 + sq;
      end
   end

   // square root, one digit per stage
   always_comb begin
      sq_in[0].valid = b_ff.valid;
      sq_in[0].rgb   = b_ff.rgb;
      sq_in[0].neg   = b_ff.neg;
      sq_in[0].zero  = (b_ff.len2 == '0);
      sq_in[0].mag   = b_ff.mag;
      sq_in[0].sr.x  = bps_pkg::SQ_W'(b_ff.len2) << bps_pkg::FRAC_SH;
      sq_in[0].sr.r  = '0;
      for (int j = 0; j < bps_pkg::SQ_STEPS; j++) begin
         sq_in[j+1]    = sq_ff[j];
         sq_in[j+1].sr = bps_pkg::sqrt_step(sq_ff[j].sr, 5'(bps_pkg::SQ_STEPS - 1 - j));
      end
   end

   // three dividers, one quotient bit per stage
   always_comb begin
      div_in[0].valid = sq_ff[bps_pkg::SQ_STEPS].valid;
      div_in[0].rgb   = sq_ff[bps_pkg::SQ_STEPS].rgb;
      div_in[0].neg   = sq_ff[bps_pkg::SQ_STEPS].neg;
      div_in[0].zero  = sq_ff[bps_pkg::SQ_STEPS].zero;
      div_in[0].s     = sq_ff[bps_pkg::SQ_STEPS].sr.r[bps_pkg::S_W-1:0];
      for (int i = 0; i < 3; i++) begin
         div_in[0].dv[i].rem = bps_pkg::REM_W'(sq_ff[bps_pkg::SQ_STEPS].mag[i])
                               << bps_pkg::FRAC_SH;
         div_in[0].dv[i].q   = '0;
      end
      for (int j = 0; j < bps_pkg::DIV_STEPS; j++) begin
         div_in[j+1] = div_ff[j];
         for (int i = 0; i < 3; i++) begin
            div_in[j+1].dv[i] = bps_pkg::div_step(div_ff[j].dv[i], div_ff[j].s,
                                                  4'(bps_pkg::DIV_STEPS - 1 - j));
         end
      end
   end

   // limit and sign
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         out_unit_in[i] = bps_pkg::unit_comp(div_ff[bps_pkg::DIV_STEPS].dv[i].q,
                                             div_ff[bps_pkg::DIV_STEPS].neg[i],
                                             div_ff[bps_pkg::DIV_STEPS].zero);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.valid <= 1'b0;
         b_ff.valid <= 1'b0;
         for (int j = 0; j <= bps_pkg::SQ_STEPS; j++) sq_ff[j].valid <= 1'b0;
         for (int j = 0; j <= bps_pkg::DIV_STEPS; j++) div_ff[j].valid <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         a_ff         <= a_in;
         b_ff         <= b_in;
         sq_ff        <= sq_in;
         div_ff       <= div_in;
         out_valid_ff <= div_ff[bps_pkg::DIV_STEPS].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_rgb_ff  <= div_ff[bps_pkg::DIV_STEPS].rgb;
         out_unit_ff <= out_unit_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_rgb   = out_rgb_ff;
   assign out_unit  = out_unit_ff;

endmodule

### sv/bps_light_unit.sv
module bps_light_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  bps_pkg::pos_type       light_pos,
   input  bps_pkg::pos_type       camera_pos,
   output bps_pkg::light_sts_type sts
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LEN  = 3'd1;
   localparam logic [2:0] ST_SQRT = 3'd2;
   localparam logic [2:0] ST_DIVI = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_NEXT = 3'd5;

   localparam logic [1:0] VEC_LIGHT = 2'd0;
   localparam logic [1:0] VEC_VIEW  = 2'd1;
   localparam logic [1:0] VEC_HALF  = 2'd2;

   logic [2:0]                  state_ff;
   logic [1:0]                  vec_ff;
   logic [1:0]                  comp_ff;
   logic [4:0]                  k_ff;
   logic [3:0]                  bit_ff;
   logic [bps_pkg::LEN_W-1:0]   len2_ff;
   bps_pkg::sqrt_type           sr_ff;
   bps_pkg::div_type            dv_ff;
   bps_pkg::uvec_type           l_ff, v_ff, h_ff;

   logic signed [16:0]          cur [3];
   bps_pkg::mag_type            mag;
   logic                        neg;
   logic [bps_pkg::LEN_W-1:0]   len2_in;
   bps_pkg::div_type            dv_in;
   bps_pkg::unit_type           unit;

   // vector under work: light, negated camera, or their unit sum
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         case (vec_ff)
            VEC_LIGHT: cur[i] = {light_pos[i][15], light_pos[i]};
            VEC_VIEW:  cur[i] = 17'sd0 - $signed({camera_pos[i][15], camera_pos[i]});
            default:   cur[i] = $signed({l_ff[i][15], l_ff[i]})
                                + $signed({v_ff[i][15], v_ff[i]});
         endcase
      end
   end

   assign mag     = bps_pkg::abs17(cur[comp_ff]);
   assign neg     = cur[comp_ff][16];
   assign len2_in = len2_ff + 32'(mag) * 32'(mag);
   assign dv_in   = bps_pkg::div_step(dv_ff, sr_ff.r[bps_pkg::S_W-1:0], bit_ff);
   assign unit    = bps_pkg::unit_comp(dv_in.q, neg, len2_ff == '0);

   // sequencer
   always_ff @(posedge clock) begin
      if (reset || start) begin
         state_ff <= ST_LEN;
         vec_ff   <= VEC_LIGHT;
         comp_ff  <= 2'd0;
         len2_ff  <= '0;
      end else begin
         case (state_ff)
            ST_LEN: begin
               len2_ff <= len2_in;
               if (comp_ff == 2'd2) begin
                  sr_ff.x  <= bps_pkg::SQ_W'(len2_in) << bps_pkg::FRAC_SH;
                  sr_ff.r  <= '0;
                  k_ff     <= 5'(bps_pkg::SQ_STEPS - 1);
                  state_ff <= ST_SQRT;
               end else begin
                  comp_ff <= comp_ff + 2'd1;
               end
            end
            ST_SQRT: begin
               sr_ff <= bps_pkg::sqrt_step(sr_ff, k_ff);
               k_ff  <= k_ff - 5'd1;
               if (k_ff == 5'd0) begin
                  comp_ff  <= 2'd0;
                  state_ff <= ST_DIVI;
               end
            end
            ST_DIVI: begin
               dv_ff.rem <= bps_pkg::REM_W'(mag) << bps_pkg::FRAC_SH;
               dv_ff.q   <= '0;
               bit_ff    <= 4'(bps_pkg::DIV_STEPS - 1);
               state_ff  <= ST_DIV;
            end
            ST_DIV: begin
               dv_ff  <= dv_in;
               bit_ff <= bit_ff - 4'd1;
               if (bit_ff == 4'd0) begin
                  case (vec_ff)
                     VEC_LIGHT: l_ff[comp_ff] <= unit;
                     VEC_VIEW:  v_ff[comp_ff] <= unit;
                     default:   h_ff[comp_ff] <= unit;
                  endcase
                  if (comp_ff == 2'd2) begin
                     state_ff <= ST_NEXT;
                  end else begin
                     comp_ff  <= comp_ff + 2'd1;
                     state_ff <= ST_DIVI;
                  end
               end
            end
            ST_NEXT: begin
               if (vec_ff == VEC_HALF) begin
                  state_ff <= ST_IDLE;
               end else begin
                  vec_ff   <= vec_ff + 2'd1;
                  comp_ff  <= 2'd0;
                  len2_ff  <= '0;
                  state_ff <= ST_LEN;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign sts.busy      = (state_ff != ST_IDLE);
   assign sts.light_dir = l_ff;
   assign sts.half_dir  = h_ff;

endmodule

### sv/bps_shade_pipe.sv
module bps_shade_pipe (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic [23:0]        in_rgb,
   input  bps_pkg::uvec_type  in_unit,
   input  bps_pkg::uvec_type  light_dir,
   input  bps_pkg::uvec_type  half_dir,
   input  logic [29:0]        light_colour,
   output logic               out_valid,
   output logic [23:0]        out_rgb
);

   typedef struct packed {
      logic        valid;
      logic [23:0] rgb;
      logic [14:0] diff;
      logic [14:0] spec;
   } shd_pw_type;

   // dot product stage
   logic                v1_ff;
   logic [23:0]         rgb1_ff;
   logic signed [29:0]  pd1_ff [3];
   logic signed [29:0]  ps1_ff [3];
   // power stages
   shd_pw_type          pw_ff [0:4];
   shd_pw_type          pw_in [0:4];
   // constant products
   logic                v7_ff;
   logic [23:0]         rgb7_ff;
   logic [30:0]         kdd7_ff;
   logic [36:0]         kss7_ff;
   // light colour products
   logic                v8_ff;
   logic [23:0]         rgb8_ff;
   logic [40:0]         dt8_ff [3];
   logic [46:0]         st8_ff [3];
   // ambient plus diffuse
   logic                v9_ff;
   logic [23:0]         rgb9_ff;
   logic [40:0]         fc9_ff [3];
   logic [46:0]         st9_ff [3];
   // base colour times factor
   logic                v10_ff;
   logic [48:0]         cf10_ff [3];
   logic [46:0]         st10_ff [3];
   // output
   logic                v11_ff;
   logic [23:0]         rgb11_ff;

   logic signed [31:0]  pd [3];
   logic signed [31:0]  ps [3];
   logic [31:0]         kdd;
   logic [37:0]         kss;
   logic [40:0]         dt [3];
   logic [46:0]         st [3];
   logic [48:0]         cf [3];
   logic [49:0]         total [3];
   logic [23:0]         rgb_out;

   // clamp to 0..1 in Q2.28, give Q1.14
   function automatic logic [14:0] dot_clamp(logic signed [31:0] d);
      logic [31:0] c;
      if (d < 0) c = '0;
      else if (d > 32'sd268435456) c = 32'd268435456;
      else c = 32'(d);
      return c[28:14];
   endfunction

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pd[i] = $signed(in_unit[i]) * $signed(light_dir[i]);
         ps[i] = $signed(in_unit[i]) * $signed(half_dir[i]);
      end
   end

   // sums and pow16 squarings
   always_comb begin
      logic signed [31:0] dsum;
      logic signed [31:0] ssum;
      logic [29:0]        sqp;
      dsum = 32'(pd1_ff[0]) + 32'(pd1_ff[1]) + 32'(pd1_ff[2]);
      ssum = 32'(ps1_ff[0]) + 32'(ps1_ff[1]) + 32'(ps1_ff[2]);
      pw_in[0].valid = v1_ff;
      pw_in[0].rgb   = rgb1_ff;
      pw_in[0].diff  = dot_clamp(dsum);
      pw_in[0].spec  = dot_clamp(ssum);
      for (int j = 0; j < 4; j++) begin
         sqp = 30'(pw_ff[j].spec) * 30'(pw_ff[j].spec);
         pw_in[j+1]      = pw_ff[j];
         pw_in[j+1].spec = sqp[28:14];
      end
   end

   assign kdd = 32'(bps_pkg::KD_Q16) * 32'(pw_ff[4].diff);
   assign kss = 38'(bps_pkg::KS255_Q16) * 38'(pw_ff[4].spec);

   // per channel terms; channel 0 is blue
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         dt[c]    = 41'(kdd7_ff) * 41'(light_colour[10*c +: 10]);
         st[c]    = 47'(kss7_ff) * 47'(light_colour[10*c +: 10]);
         cf[c]    = 49'(rgb9_ff[8*c +: 8]) * 49'(fc9_ff[c]);
         total[c] = 50'(cf10_ff[c]) + 50'(st10_ff[c]);
         rgb_out[8*c +: 8] = (total[c][49:38] > 12'd255) ? 8'd255 : total[c][45:38];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         for (int j = 0; j < 5; j++) pw_ff[j].valid <= 1'b0;
         v7_ff  <= 1'b0;
         v8_ff  <= 1'b0;
         v9_ff  <= 1'b0;
         v10_ff <= 1'b0;
         v11_ff <= 1'b0;
      end else if (en) begin
         v1_ff  <= in_valid;
         pw_ff  <= pw_in;
         v7_ff  <= pw_ff[4].valid;
         v8_ff  <= v7_ff;
         v9_ff  <= v8_ff;
         v10_ff <= v9_ff;
         v11_ff <= v10_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rgb1_ff <= in_rgb;
         for (int i = 0; i < 3; i++) begin
            pd1_ff[i] <= pd[i][29:0];
            ps1_ff[i] <= ps[i][29:0];
         end
         rgb7_ff <= pw_ff[4].rgb;
         kdd7_ff <= kdd[30:0];
         kss7_ff <= kss[36:0];
         rgb8_ff <= rgb7_ff;
         rgb9_ff <= rgb8_ff;
         for (int c = 0; c < 3; c++) begin
            dt8_ff[c]  <= dt[c];
            st8_ff[c]  <= st[c];
            fc9_ff[c]  <= (41'(bps_pkg::KA_Q16) << 22) + dt8_ff[c];
            st9_ff[c]  <= st8_ff[c];
            cf10_ff[c] <= cf[c];
            st10_ff[c] <= st9_ff[c];
         end
         rgb11_ff <= rgb_out;
      end
   end

   assign out_valid = v11_ff;
   assign out_rgb   = rgb11_ff;

endmodule

### tb/blinn_phong_pixel_shade_test.sv
module blinn_phong_pixel_shade_test;

   // expected shaded pixels, predicted from the register copy
   class shade_scoreboard;
      logic [15:0] light_pos [3];
      logic [15:0] camera_pos [3];
      logic [29:0] light_col;
      logic [23:0] shaded_q [$];

      function new();
         light_pos[0] = 16'd640;
         light_pos[1] = 16'd1536;
         light_pos[2] = 16'd1024;
         camera_pos[0] = 16'd0;
         camera_pos[1] = 16'd0;
         camera_pos[2] = 16'hff00;
         light_col = 30'd268697856;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] val);
         case (idx)
            bps_pkg::REG_LIGHT_X: light_pos[0] = val[15:0];
            bps_pkg::REG_LIGHT_Y: light_pos[1] = val[15:0];
            bps_pkg::REG_LIGHT_Z: light_pos[2] = val[15:0];
            bps_pkg::REG_CAMERA_X: camera_pos[0] = val[15:0];
            bps_pkg::REG_CAMERA_Y: camera_pos[1] = val[15:0];
            bps_pkg::REG_CAMERA_Z: camera_pos[2] = val[15:0];
            bps_pkg::REG_COLOUR: light_col = val[29:0];
            default: ;
         endcase
      endfunction

      function longint unsigned floor_sqrt(longint unsigned x);
         longint unsigned r;
         longint unsigned b;
         r = 0;
         b = 64'd1 << 62;
         while (b > x) b = b >> 2;
         while (b != 0) begin
            if (x >= r + b) begin
               x = x - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      // scale to unit length in Q1.14, zero stays zero
      function void to_unit(input longint v [3], output longint u [3]);
         longint unsigned m [3];
         longint unsigned len2;
         longint unsigned s;
         longint unsigned q;
         len2 = 0;
         for (int i = 0; i < 3; i++) begin
            m[i] = (v[i] < 0) ? -v[i] : v[i];
            len2 += m[i] * m[i];
         end
         for (int i = 0; i < 3; i++) u[i] = 0;
         if (len2 != 0) begin
            s = floor_sqrt(len2 << 28);
            for (int i = 0; i < 3; i++) begin
               q = (m[i] << 28) / s;
               if (q > 16384) q = 16384;
               u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
            end
         end
      endfunction

      function longint unsigned clamped_dot(longint a [3], longint b [3]);
         longint d;
         d = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
         if (d < 0) d = 0;
         if (d > (64'sd1 <<< 28)) d = 64'sd1 <<< 28;
         return longint'(d) >> 14;
      endfunction

      function logic [7:0] channel(longint unsigned c, longint unsigned lc,
                                   longint unsigned diff, longint unsigned spec);
         longint unsigned factor;
         longint unsigned sum;
         factor = (longint'(14418) << 22) + 64'd45875 * diff * lc;
         sum = c * factor + 64'd4679250 * spec * lc;
         sum = sum >> 38;
         return (sum > 255) ? 8'hff : sum[7:0];
      endfunction

      function void note_pixel(logic [71:0] word);
         longint nv [3], lv [3], vv [3], hv [3];
         longint n [3], l [3], v [3], h [3];
         longint unsigned diff, spec;
         logic [23:0] rgb;
         for (int i = 0; i < 3; i++) begin
            nv[i] = longint'($signed(word[24 + 16*i +: 16]));
            lv[i] = longint'($signed(light_pos[i]));
            vv[i] = -longint'($signed(camera_pos[i]));
         end
         to_unit(nv, n);
         to_unit(lv, l);
         to_unit(vv, v);
         for (int i = 0; i < 3; i++) hv[i] = l[i] + v[i];
         to_unit(hv, h);
         diff = clamped_dot(n, l);
         spec = clamped_dot(n, h);
         for (int i = 0; i < 4; i++) spec = (spec * spec) >> 14;
         rgb = word[23:0];
         shaded_q.push_back({channel(rgb[23:16], light_col[29:20], diff, spec),
                             channel(rgb[15:8], light_col[19:10], diff, spec),
                             channel(rgb[7:0], light_col[9:0], diff, spec)});
      endfunction

      // 0 ok, 1 no expectation, 2 wrong value
      function int check_rgb(logic [23:0] got, output logic [23:0] want);
         want = 24'h0;
         if (shaded_q.size() == 0) return 1;
         want = shaded_q.pop_front();
         return (got === want) ? 0 : 2;
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;   // pixel_rgb, normal_x, normal_y, normal_z
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // shaded_rgb
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   shade_scoreboard sb = new();
   int  error_count = 0;
   int  pixels_in = 0;
   int  pixels_out = 0;
   int  settings = 1;
   int  idle_cycles = 0;
   bit  req_fire = 1'b0;
   bit  steady = 1'b0;
   int  rsp_hold = 0;

   localparam int WATCHDOG = 6000;

   blinn_phong_pixel_shade u_top (.*);

   always #6 clock = ~clock;

   task automatic report(string what, logic [23:0] got, logic [23:0] want);
      $display("mismatch %s: got %06h want %06h at word %0d", what, got, want, pixels_out);
      error_count++;
   endtask

   // monitors, sampled at the rising edge
   always @(posedge clock) begin
      logic [23:0] want;
      int st;
      req_fire = req_tvalid && req_tready && !reset;
      if (req_fire) begin
         sb.note_pixel(req_tdata);
         pixels_in++;
      end
      if (rsp_tvalid && rsp_tready && !reset) begin
         st = sb.check_rgb(rsp_tdata, want);
         if (st == 1) report("unexpected word", rsp_tdata, want);
         else if (st == 2) report("shaded_rgb", rsp_tdata, want);
         pixels_out++;
      end
      if (req_fire || (rsp_tvalid && rsp_tready) || reset) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
         $display("watchdog expired with %0d words pending", sb.shaded_q.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // output side stalls
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_tready <= 1'b1;
         rsp_hold = gap_len();
      end
   end

   task automatic send_pixel(logic [23:0] rgb, logic [15:0] nx, logic [15:0] ny,
                             logic [15:0] nz);
      int gap;
      req_tdata <= {nz, ny, nx, rgb};
      req_tvalid <= 1'b1;
      do @(negedge clock); while (!req_fire);
      gap = gap_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.shaded_q.size() != 0) @(negedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      sb.write_reg(idx, val);
   endtask

   task automatic set_scene(logic [15:0] lx, logic [15:0] ly, logic [15:0] lz,
                            logic [15:0] cx, logic [15:0] cy, logic [15:0] cz,
                            logic [31:0] col);
      drain();
      write_reg(bps_pkg::REG_LIGHT_X, {16'($urandom_range(0, 65535)), lx});
      write_reg(bps_pkg::REG_LIGHT_Y, 32'(ly));
      write_reg(bps_pkg::REG_LIGHT_Z, 32'(lz));
      write_reg(bps_pkg::REG_CAMERA_X, 32'(cx));
      write_reg(bps_pkg::REG_CAMERA_Y, 32'(cy));
      write_reg(bps_pkg::REG_CAMERA_Z, {16'($urandom_range(0, 65535)), cz});
      write_reg(bps_pkg::REG_COLOUR, col);
      settings++;
   endtask

   function automatic logic [15:0] rand_comp();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'($signed($urandom_range(0, 200)) - 100);
         3: return 16'($signed($urandom_range(0, 32768)) - 16384);
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic random_pixels(int count, bit pause_midway);
      logic [15:0] c [3];
      steady = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < count; k++) begin
         if (pause_midway && k == count / 2) drain();
         for (int i = 0; i < 3; i++) c[i] = rand_comp();
         if ($urandom_range(0, 19) == 0) c = '{16'h0, 16'h0, 16'h0};
         send_pixel(24'($urandom_range(0, 24'hffffff)), c[0], c[1], c[2]);
      end
      steady = 1'b0;
   endtask

   initial begin
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // directed pixels at the reset scene
      send_pixel(24'hffffff, 16'h0, 16'h0, 16'h0);
      send_pixel(24'hffffff, 16'h0, 16'h0, 16'h4000);
      send_pixel(24'h000000, 16'h0, 16'h0, 16'h4000);
      send_pixel(24'hff0000, 16'h0, 16'h0, 16'h7fff);
      send_pixel(24'h00ff00, 16'h0, 16'h0, 16'h8000);
      send_pixel(24'h0000ff, 16'h7fff, 16'h7fff, 16'h7fff);
      send_pixel(24'h808080, 16'h8000, 16'h8000, 16'h8000);
      send_pixel(24'hffffff, 16'd640, 16'd1536, 16'd1024);
      send_pixel(24'h123456, 16'd2560, 16'd6144, 16'd4096 + 16'd6656);
      send_pixel(24'hffffff, 16'h0001, 16'h0, 16'h0);
      send_pixel(24'hffffff, 16'h0, 16'hffff, 16'h0);
      send_pixel(24'ha5a5a5, 16'h7fff, 16'h8000, 16'h0001);
      random_pixels(100, 1'b1);

      // zero light position, brightest light
      set_scene(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'hff00, 32'hffffffff);
      send_pixel(24'hffffff, 16'h0, 16'h0, 16'h4000);
      random_pixels(60, 1'b0);

      // light opposite the view, half vector vanishes
      set_scene(16'h0, 16'h0, 16'h0100, 16'h0, 16'h0, 16'h0100, 32'h3fffffff);
      send_pixel(24'hffffff, 16'h0, 16'h0, 16'h4000);
      random_pixels(60, 1'b0);

      // extreme positions, black light, then a stray write past the last register
      set_scene(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 32'h0);
      write_reg(3'd7, 32'hffffffff);
      random_pixels(60, 1'b0);

      // random scenes
      repeat (6) begin
         set_scene(rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                   rand_comp(), $urandom());
         random_pixels(70, 1'($urandom_range(0, 1)));
      end

      drain();
      repeat (80) @(negedge clock);
      $display("shaded %0d pixels (%0d checked) over %0d light and camera settings",
               pixels_in, pixels_out, settings);
      $display("mismatches: %0d, words left over: %0d", error_count, sb.shaded_q.size());
      if (error_count == 0 && sb.shaded_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

### sim.f
sv/bps_pkg.sv
sv/bps_norm_pipe.sv
sv/bps_light_unit.sv
sv/bps_shade_pipe.sv
sv/blinn_phong_pixel_shade.sv
tb/blinn_phong_pixel_shade_test.sv
